@@ rtl/chunked_tile_grid_store_macros.svh @@
// Assertion macros for the checker of the tile grid store.
`ifndef CHUNKED_TILE_GRID_STORE_MACROS_SVH
`define CHUNKED_TILE_GRID_STORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CTGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CTGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ctgs_pkg.sv @@
package ctgs_pkg;

  // Default sizing of the grid
  localparam int MAX_CHUNKS      = 64;
  localparam int MAX_CHUNK_SHIFT = 4;

  // Fixed field widths
  localparam int VALUE_BITS = 8;
  localparam int COORD_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SHIFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT_Z = 3'd3;

  // Register reset values
  localparam logic [SHIFT_W-1:0] RST_CHUNK_SHIFT = 3'd4;
  localparam logic [COUNT_W-1:0] RST_CHUNK_COUNT = 7'd4;

  // Actions
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Value held by every tile of a freshly allocated chunk
  localparam logic [VALUE_BITS-1:0] EMPTY_VALUE = VALUE_BITS'(1);

endpackage

@@ rtl/ctgs_ram.sv @@
// Simple dual-port RAM: one write port, one read port, registered read data.
module ctgs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/chunked_tile_grid_store.sv @@
// Channel | Direction | Handshake              | Words
// in      | to block  | in_valid / in_stall    | action, tile_x/y/z, write_value
// out     | from block| out_valid / out_stall  | read_value, is_empty, in_bounds,
//         |           |                        | was_allocated
// cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item passes these steps from accept until its result is loaded into the
// output register: bounds, two multiply steps for the linear chunk index, one
// read of the allocation and tile RAMs, then the result select.
// The next word is taken in the cycle after the load at the earliest. A write
// to an in-range chunk not yet allocated first fills every tile of the chunk
// with the empty value through the tile RAM's write port. After reset all
// MAX_CHUNKS allocation RAM entries are cleared, with in_stall high. A result
// waiting on out_stall does not block the next accept.
module chunked_tile_grid_store #(
  parameter int MAX_CHUNKS      = ctgs_pkg::MAX_CHUNKS,
  parameter int MAX_CHUNK_SHIFT = ctgs_pkg::MAX_CHUNK_SHIFT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [ctgs_pkg::COORD_W-1:0]        tile_x,
  input  logic [ctgs_pkg::COORD_W-1:0]        tile_y,
  input  logic [ctgs_pkg::COORD_W-1:0]        tile_z,
  input  logic [ctgs_pkg::VALUE_BITS-1:0]     write_value,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ctgs_pkg::VALUE_BITS-1:0]     read_value,
  output logic                                is_empty,
  output logic                                in_bounds,
  output logic                                was_allocated,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctgs_pkg::COUNT_W-1:0]        cfg_data
);

  localparam int CHUNK_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OFF_W     = 2 * MAX_CHUNK_SHIFT;
  localparam int TILE_AW   = CHUNK_W + OFF_W;
  localparam int TILE_DEP  = MAX_CHUNKS * (1 << OFF_W);
  localparam int CW        = ctgs_pkg::COUNT_W;
  localparam int PROD_W    = 2 * CW;
  localparam int LIN_W     = 3 * CW + 1;
  localparam int VB        = ctgs_pkg::VALUE_BITS;

  // State codes
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_LIN    = 4'd3;
  localparam logic [3:0] S_LOOK   = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_FILL   = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Configuration registers
  logic [ctgs_pkg::SHIFT_W-1:0] chunk_shift;
  logic [CW-1:0]                chunk_count_x;
  logic [CW-1:0]                chunk_count_y;
  logic [CW-1:0]                chunk_count_z;

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [CHUNK_W-1:0]   clr_cnt;
  logic [OFF_W-1:0]     fill_cnt;

  // Item registers
  logic                 act;
  logic [VB-1:0]        wval;
  logic [CW-1:0]        cx;
  logic [CW-1:0]        cy;
  logic [CW-1:0]        cz;
  logic                 coord_ok;
  logic [OFF_W-1:0]     offset;
  logic [PROD_W-1:0]    row_part;
  logic [PROD_W-1:0]    layer_size;
  logic [CHUNK_W-1:0]   lin;
  logic                 inb;
  logic                 alloc;
  logic [VB-1:0]        res_value;

  // Combinational index math
  logic [ctgs_pkg::SHIFT_W-1:0] sh;
  logic [MAX_CHUNK_SHIFT-1:0]   off_mask;
  logic [MAX_CHUNK_SHIFT-1:0]   ox;
  logic [MAX_CHUNK_SHIFT-1:0]   oy;
  logic [ctgs_pkg::COORD_W-1:0] sx;
  logic [ctgs_pkg::COORD_W-1:0] sy;
  logic [ctgs_pkg::COORD_W-1:0] sz;
  logic [LIN_W-1:0]             lin_full;
  logic [TILE_AW-1:0]           tile_addr;

  // RAM ports
  logic                 alloc_we;
  logic [CHUNK_W-1:0]   alloc_waddr;
  logic [0:0]           alloc_wdata;
  logic [0:0]           alloc_rdata;
  logic                 tile_we;
  logic [TILE_AW-1:0]   tile_waddr;
  logic [VB-1:0]        tile_wdata;
  logic [VB-1:0]        tile_rdata;

  logic accept;
  logic out_load;
  logic chk_alloc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign chk_alloc = inb && alloc_rdata[0];

  // Effective shift, clamped to the largest chunk side
  assign sh = ({1'b0, chunk_shift} > (ctgs_pkg::SHIFT_W + 1)'(MAX_CHUNK_SHIFT)) ?
              ctgs_pkg::SHIFT_W'(MAX_CHUNK_SHIFT) : chunk_shift;

  // Split coordinates into chunk index and in-chunk offset
  assign off_mask = ~({MAX_CHUNK_SHIFT{1'b1}} << sh);
  assign ox       = tile_x[MAX_CHUNK_SHIFT-1:0] & off_mask;
  assign oy       = tile_y[MAX_CHUNK_SHIFT-1:0] & off_mask;
  assign sx       = tile_x >> sh;
  assign sy       = tile_y >> sh;
  assign sz       = tile_z >> sh;

  // Linear chunk index
  assign lin_full = LIN_W'(cz) * LIN_W'(layer_size) + LIN_W'(row_part) + LIN_W'(cx);
  assign tile_addr = {lin, offset};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_shift   <= ctgs_pkg::RST_CHUNK_SHIFT;
      chunk_count_x <= ctgs_pkg::RST_CHUNK_COUNT;
      chunk_count_y <= ctgs_pkg::RST_CHUNK_COUNT;
      chunk_count_z <= ctgs_pkg::RST_CHUNK_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctgs_pkg::REG_CHUNK_SHIFT:   chunk_shift   <= cfg_data[ctgs_pkg::SHIFT_W-1:0];
        ctgs_pkg::REG_CHUNK_COUNT_X: chunk_count_x <= cfg_data;
        ctgs_pkg::REG_CHUNK_COUNT_Y: chunk_count_y <= cfg_data;
        ctgs_pkg::REG_CHUNK_COUNT_Z: chunk_count_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == CHUNK_W'(MAX_CHUNKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_MUL;
      end
      S_MUL:  state_next = S_LIN;
      S_LIN:  state_next = S_LOOK;
      S_LOOK: state_next = S_CHECK;
      S_CHECK: begin
        if (inb && (act == ctgs_pkg::ACT_WRITE) && !alloc_rdata[0]) begin
          state_next = S_FILL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        if (&fill_cnt) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      fill_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + CHUNK_W'(1);
      if (state == S_CHECK) fill_cnt <= '0;
      else if (state == S_FILL) fill_cnt <= fill_cnt + OFF_W'(1);
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action;
      wval     <= write_value;
      cx       <= sx[CW-1:0];
      cy       <= sy[CW-1:0];
      cz       <= sz[CW-1:0];
      coord_ok <= (sx < ctgs_pkg::COORD_W'(chunk_count_x)) &&
                  (sy < ctgs_pkg::COORD_W'(chunk_count_y)) &&
                  (sz < ctgs_pkg::COORD_W'(chunk_count_z));
      offset   <= (OFF_W'(oy) << sh) | OFF_W'(ox);
    end
    if (state == S_MUL) begin
      row_part   <= PROD_W'(cy) * PROD_W'(chunk_count_x);
      layer_size <= PROD_W'(chunk_count_y) * PROD_W'(chunk_count_x);
    end
    if (state == S_LIN) begin
      lin <= lin_full[CHUNK_W-1:0];
      inb <= coord_ok && (lin_full < LIN_W'(MAX_CHUNKS));
    end
    if (state == S_CHECK) begin
      alloc <= chk_alloc;
      if (inb && (act == ctgs_pkg::ACT_WRITE)) begin
        res_value <= wval;
      end else if (chk_alloc) begin
        res_value <= tile_rdata;
      end else begin
        res_value <= '0;
      end
    end
  end

  // Allocation RAM write: clear pass, then marks on first write
  always_comb begin
    alloc_we    = 1'b0;
    alloc_waddr = lin;
    alloc_wdata = 1'b1;
    if (state == S_CLEAR) begin
      alloc_we    = 1'b1;
      alloc_waddr = clr_cnt;
      alloc_wdata = 1'b0;
    end else if (state == S_COMMIT) begin
      alloc_we = 1'b1;
    end
  end

  // Tile RAM write: fill sweep or the item's own value
  always_comb begin
    tile_we    = 1'b0;
    tile_waddr = tile_addr;
    tile_wdata = wval;
    if (state == S_FILL) begin
      tile_we    = 1'b1;
      tile_waddr = {lin, fill_cnt};
      tile_wdata = ctgs_pkg::EMPTY_VALUE;
    end else if (state == S_COMMIT) begin
      tile_we = 1'b1;
    end else if ((state == S_CHECK) && (act == ctgs_pkg::ACT_WRITE) && chk_alloc) begin
      tile_we = 1'b1;
    end
  end

  ctgs_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS)
  ) u_alloc_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (alloc_waddr),
    .wdata (alloc_wdata),
    .raddr (lin),
    .rdata (alloc_rdata)
  );

  ctgs_ram #(
    .WIDTH (VB),
    .DEPTH (TILE_DEP)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .raddr (tile_addr),
    .rdata (tile_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_value    <= res_value;
      is_empty      <= (res_value == ctgs_pkg::EMPTY_VALUE);
      in_bounds     <= inb;
      was_allocated <= alloc;
    end
  end

endmodule

@@ rtl/ctgs_checker.sv @@
`include "chunked_tile_grid_store_macros.svh"

// Port-level checks on the tile grid store.
module ctgs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ctgs_pkg::VALUE_BITS-1:0] read_value,
  input logic                            is_empty,
  input logic                            in_bounds,
  input logic                            was_allocated
);

  // A waiting result is not dropped
  `CTGS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")

  // Empty flag tracks the value
  `CTGS_ASSERT_NOW(a_empty_flag, clk, rst, out_valid, is_empty == (read_value == ctgs_pkg::EMPTY_VALUE), "is_empty disagrees with read_value")

  // Out-of-range chunk reads zero and was never allocated
  `CTGS_ASSERT_NOW(a_oob_zero, clk, rst, out_valid && !in_bounds, (read_value == '0) && !was_allocated, "out-of-range item gave data")

  // One item at a time: input closes right after an accept
  `CTGS_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall, "second item accepted back to back")

endmodule

bind chunked_tile_grid_store ctgs_checker u_ctgs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .read_value    (read_value),
  .is_empty      (is_empty),
  .in_bounds     (in_bounds),
  .was_allocated (was_allocated)
);
